// ----- rtl/lzd_pkg.sv -----
// Shared types, code tables and symbol encoding for the deflate compressor.
`default_nettype none
package lzd_pkg;

	localparam int PIECE_W = 20;
	localparam int LEN_W = 9;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_CAP  = 2'd1;
	localparam logic [1:0] ERR_LONG = 2'd2;

	typedef struct packed {
		logic               valid;
		logic               fin;
		logic [PIECE_W-1:0] bits;
		logic [4:0]         n;
	} pk_req_t;

	typedef struct packed {
		logic [8:0] bits;
		logic [3:0] n;
	} sym_t;

	localparam logic [8:0] LEN_BASE [29] = '{9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9,
		9'd10, 9'd11, 9'd13, 9'd15, 9'd17, 9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43,
		9'd51, 9'd59, 9'd67, 9'd83, 9'd99, 9'd115, 9'd131, 9'd163, 9'd195, 9'd227,
		9'd258};
	localparam logic [2:0] LEN_EXTRA [29] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd0};
	localparam logic [15:0] DIST_BASE [30] = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5,
		16'd7, 16'd9, 16'd13, 16'd17, 16'd25, 16'd33, 16'd49, 16'd65, 16'd97, 16'd129,
		16'd193, 16'd257, 16'd385, 16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049,
		16'd3073, 16'd4097, 16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577};
	localparam logic [3:0] DIST_EXTRA [30] = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1,
		4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8,
		4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

	// fixed Huffman code, bit-reversed so it can be shifted out LSB first
	function automatic sym_t sym_piece(input logic [8:0] sym);
		logic [8:0] code;
		logic [3:0] len;
		sym_t r;
		if (sym <= 9'd143) begin
			code = 9'h030 + sym;
			len = 4'd8;
		end else if (sym <= 9'd255) begin
			code = 9'h190 + (sym - 9'd144);
			len = 4'd9;
		end else if (sym <= 9'd279) begin
			code = sym - 9'd256;
			len = 4'd7;
		end else begin
			code = 9'h0C0 + (sym - 9'd280);
			len = 4'd8;
		end
		r.bits = '0;
		for (int j = 0; j < 9; j++) begin
			if (4'(j) < len) r.bits[j] = code[4'(len - 4'd1 - 4'(j))];
		end
		r.n = len;
		return r;
	endfunction

	function automatic logic [4:0] len_idx(input logic [8:0] len);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 29; i++) begin
			if (LEN_BASE[i] <= len) r = 5'(i);
		end
		return r;
	endfunction

	function automatic logic [4:0] dist_idx(input logic [15:0] dv);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 30; i++) begin
			if (DIST_BASE[i] <= dv) r = 5'(i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lz77_fixed_huffman_deflate_top.sv -----
// Top level: greedy LZ77 over a history memory and hash-head memory, fixed Huffman output.
// A byte that completes the lookahead is hashed, looked up in the hash-head memory and, on a
// hit, matched one byte at a time through the two-port history memory; its literal or match
// token then goes to the packer, which can stall. Other bytes are only stored in history.
// Output words appear in the cycle after the piece that completes them.
// Reset clears the hash table by a pass over all 2^HASH_BITS entries (8192 by default), repeated
// after every final word; no byte is taken during the pass.
`default_nettype none
module lz77_fixed_huffman_deflate_top #(
	parameter int WINDOW_SIZE   = 32768,
	parameter int HASH_BITS     = 13,
	parameter int MAX_MATCH     = 258,
	parameter int HISTORY_DEPTH = 65536,
	parameter int POSITION_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      out_word,
	output logic [3:0]       out_count,
	output logic             last_word,
	output logic [1:0]       error,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int PB = POSITION_BITS;
	localparam int HAW = $clog2(HISTORY_DEPTH);
	localparam int HASH_SIZE = 1 << HASH_BITS;
	localparam logic [PB-1:0] POS_LIMIT = '1;
	localparam logic [2:0] REG_CAP = 3'd0;

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_HDR  = 5'd2;
	localparam logic [4:0] S_LOOP = 5'd3;
	localparam logic [4:0] S_RD0  = 5'd4;
	localparam logic [4:0] S_RD1  = 5'd5;
	localparam logic [4:0] S_RD2  = 5'd6;
	localparam logic [4:0] S_HRD  = 5'd7;
	localparam logic [4:0] S_HCK  = 5'd8;
	localparam logic [4:0] S_MRD  = 5'd9;
	localparam logic [4:0] S_MCMP = 5'd10;
	localparam logic [4:0] S_MEND = 5'd11;
	localparam logic [4:0] S_LIT  = 5'd12;
	localparam logic [4:0] S_MAT1 = 5'd13;
	localparam logic [4:0] S_MAT2 = 5'd14;
	localparam logic [4:0] S_END  = 5'd15;
	localparam logic [4:0] S_FIN  = 5'd16;

	logic [4:0]           state_q;
	logic [HASH_BITS-1:0] clr_q;
	logic [PB-1:0]        br_q;
	logic [PB-1:0]        ep_q;
	logic                 hdr_q;
	logic                 last_q;
	logic [31:0]          cap_q;
	logic [7:0]           b0_q;
	logic [7:0]           b1_q;
	logic [HASH_BITS-1:0] idx_q;
	logic [PB-1:0]        cand_q;
	logic [lzd_pkg::LEN_W-1:0] m_q;
	logic [lzd_pkg::LEN_W-1:0] maxlen_q;

	logic [7:0] hist_mem [HISTORY_DEPTH];
	logic [7:0] rda_q;
	logic [7:0] rdb_q;
	logic [PB:0] hash_mem [HASH_SIZE];
	logic [PB:0] hrd_q;

	logic                 hist_we;
	logic [PB-1:0]        pa;
	logic [PB-1:0]        pb;
	logic                 h_we;
	logic [HASH_BITS-1:0] h_wa;
	logic [PB:0]          h_wd;
	logic [PB-1:0]        avail;
	logic [31:0]          prod;
	logic [PB-1:0]        hp;
	logic                 hit;
	logic                 accept;
	logic                 err2;
	logic                 pk_ready;
	lzd_pkg::pk_req_t     req;
	lzd_pkg::sym_t        sp;
	lzd_pkg::sym_t        lsp;
	logic [4:0]           li;
	logic [4:0]           di;
	logic [15:0]          dist_v;
	logic [4:0]           dcode_r;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign err2 = accept && (br_q == POS_LIMIT);
	assign hist_we = accept && (br_q != POS_LIMIT);
	assign avail = br_q - ep_q;
	assign pready = 1'b1;
	assign prdata = (paddr == REG_CAP) ? cap_q : 32'd0;

	always_comb begin
		pa = ep_q;
		pb = ep_q + PB'(1);
		if (state_q == S_RD1) pa = ep_q + PB'(2);
		if (state_q == S_MRD) begin
			pa = cand_q + PB'(m_q);
			pb = ep_q + PB'(m_q);
		end
		prod = 32'({8'd0, b0_q, b1_q, rda_q} * 32'd2654435761);
		hp = hrd_q[PB-1:0];
		hit = hrd_q[PB] && (hp < ep_q) && ((ep_q - hp) <= PB'(WINDOW_SIZE));
		h_we = (state_q == S_CLR) || (state_q == S_HCK);
		h_wa = (state_q == S_CLR) ? clr_q : idx_q;
		h_wd = (state_q == S_CLR) ? '0 : {1'b1, ep_q};
	end

	always_comb begin
		sp = lzd_pkg::sym_piece({1'b0, b0_q});
		li = lzd_pkg::len_idx(m_q);
		lsp = lzd_pkg::sym_piece(9'd257 + 9'(li));
		dist_v = 16'(ep_q - cand_q);
		di = lzd_pkg::dist_idx(dist_v);
		for (int j = 0; j < 5; j++) dcode_r[j] = di[4 - j];
		req = '0;
		unique case (state_q)
			S_HDR: begin
				// BFINAL then BTYPE=01
				req.valid = 1'b1;
				req.bits = lzd_pkg::PIECE_W'(3'b011);
				req.n = 5'd3;
			end
			S_LIT: begin
				req.valid = 1'b1;
				req.bits = lzd_pkg::PIECE_W'(sp.bits);
				req.n = 5'(sp.n);
			end
			S_MAT1: begin
				req.valid = 1'b1;
				req.bits = lzd_pkg::PIECE_W'(lsp.bits)
					| (lzd_pkg::PIECE_W'(m_q - lzd_pkg::LEN_BASE[li]) << lsp.n);
				req.n = 5'(lsp.n) + 5'(lzd_pkg::LEN_EXTRA[li]);
			end
			S_MAT2: begin
				req.valid = 1'b1;
				req.bits = lzd_pkg::PIECE_W'(dcode_r)
					| (lzd_pkg::PIECE_W'(dist_v - lzd_pkg::DIST_BASE[di]) << 5);
				req.n = 5'd5 + 5'(lzd_pkg::DIST_EXTRA[di]);
			end
			S_END: begin
				req.valid = 1'b1;
				req.n = 5'd7;
			end
			S_FIN: begin
				req.valid = 1'b1;
				req.fin = 1'b1;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[br_q[HAW-1:0]] <= data_byte;
		rda_q <= hist_mem[pa[HAW-1:0]];
		rdb_q <= hist_mem[pb[HAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (h_we) hash_mem[h_wa] <= h_wd;
		hrd_q <= hash_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD1) begin
			b0_q <= rda_q;
			b1_q <= rdb_q;
		end
		if (state_q == S_RD2) begin
			idx_q <= prod[31 -: HASH_BITS];
			maxlen_q <= (avail < PB'(MAX_MATCH)) ? avail[lzd_pkg::LEN_W-1:0]
				: lzd_pkg::LEN_W'(MAX_MATCH);
		end
		if (state_q == S_HCK) cand_q <= hp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '1;
		end else if (psel && penable && pwrite && paddr == REG_CAP) begin
			cap_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			br_q <= '0;
			ep_q <= '0;
			hdr_q <= 1'b0;
			last_q <= 1'b0;
			m_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						last_q <= last_byte;
						if (br_q != POS_LIMIT) br_q <= br_q + PB'(1);
						state_q <= hdr_q ? S_LOOP : S_HDR;
					end
				end
				S_HDR: begin
					if (pk_ready) begin
						hdr_q <= 1'b1;
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					priority if (avail >= PB'(MAX_MATCH) || (last_q && ep_q < br_q))
						state_q <= S_RD0;
					else if (last_q)
						state_q <= S_END;
					else
						state_q <= S_IDLE;
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= (avail >= PB'(3)) ? S_RD2 : S_LIT;
				S_RD2: state_q <= S_HRD;
				S_HRD: state_q <= S_HCK;
				S_HCK: begin
					m_q <= '0;
					state_q <= hit ? S_MRD : S_LIT;
				end
				S_MRD: state_q <= (m_q < maxlen_q) ? S_MCMP : S_MEND;
				S_MCMP: begin
					if (rda_q == rdb_q) begin
						m_q <= m_q + 1'b1;
						state_q <= S_MRD;
					end else begin
						state_q <= S_MEND;
					end
				end
				S_MEND: state_q <= (m_q >= lzd_pkg::LEN_W'(3)) ? S_MAT1 : S_LIT;
				S_LIT: begin
					if (pk_ready) begin
						ep_q <= ep_q + PB'(1);
						state_q <= S_LOOP;
					end
				end
				S_MAT1: if (pk_ready) state_q <= S_MAT2;
				S_MAT2: begin
					if (pk_ready) begin
						ep_q <= ep_q + PB'(m_q);
						state_q <= S_LOOP;
					end
				end
				S_END: if (pk_ready) state_q <= S_FIN;
				S_FIN: begin
					// stream done: drop all stream state and wipe the hash table
					if (pk_ready) begin
						br_q <= '0;
						ep_q <= '0;
						hdr_q <= 1'b0;
						last_q <= 1'b0;
						clr_q <= '0;
						state_q <= S_CLR;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	lzd_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ready     (pk_ready),
		.cap       (cap_q),
		.err2      (err2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.out_count (out_count),
		.last_word (last_word),
		.error     (error)
	);

endmodule
`default_nettype wire

// ----- rtl/lzd_packer.sv -----
// Bit packer: collects code pieces LSB first and emits capacity-limited output words.
`default_nettype none
module lzd_packer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lzd_pkg::pk_req_t req,
	output logic                 ready,
	input  wire logic [31:0]     cap,
	input  wire logic            err2,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [63:0]          out_word,
	output logic [3:0]           out_count,
	output logic                 last_word,
	output logic [1:0]           error
);

	logic [63:0] pend_q;
	logic [6:0]  cnt_q;
	logic [31:0] wr_q;
	logic [1:0]  err_q;
	logic        ov_q;
	logic [63:0] word_q;
	logic [3:0]  count_q;
	logic        lastw_q;
	logic [1:0]  eout_q;

	logic        take;
	logic [7:0]  sum;
	logic        ovf;
	logic [63:0] fill;
	logic [63:0] rest;
	logic [3:0]  nb;
	logic [63:0] src;
	logic [31:0] room;
	logic [3:0]  fit;
	logic [63:0] masked;
	logic        show;
	logic [1:0]  err_new;

	assign ready = !ov_q || !out_stall;
	assign take = req.valid && ready;

	always_comb begin
		sum = 8'(cnt_q) + 8'(req.n);
		ovf = sum > 8'd64;
		fill = pend_q | (64'(req.bits) << cnt_q);
		rest = 64'(req.bits) >> (7'd64 - cnt_q);
		nb = req.fin ? 4'((8'(cnt_q) + 8'd7) >> 3) : 4'd8;
		src = req.fin ? pend_q : fill;
		room = (cap > wr_q) ? (cap - wr_q) : 32'd0;
		fit = (room < 32'(nb)) ? room[3:0] : nb;
		for (int k = 0; k < 8; k++) begin
			masked[8*k +: 8] = (4'(k) < fit) ? src[8*k +: 8] : 8'd0;
		end
		err_new = (err_q == lzd_pkg::ERR_NONE && fit < nb) ? lzd_pkg::ERR_CAP : err_q;
		// a full word with no room left is dropped; the final word always goes out
		show = take && (req.fin || ovf) && !(fit == 4'd0 && !req.fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q <= '0;
			wr_q <= '0;
			err_q <= lzd_pkg::ERR_NONE;
			ov_q <= 1'b0;
		end else begin
			if (take) begin
				if (req.fin) begin
					pend_q <= '0;
					cnt_q <= '0;
					wr_q <= '0;
					err_q <= lzd_pkg::ERR_NONE;
				end else if (ovf) begin
					pend_q <= rest;
					cnt_q <= 7'(sum - 8'd64);
					wr_q <= wr_q + 32'(fit);
					err_q <= err_new;
				end else begin
					pend_q <= fill;
					cnt_q <= 7'(sum);
				end
			end else if (err2 && err_q == lzd_pkg::ERR_NONE) begin
				err_q <= lzd_pkg::ERR_LONG;
			end
			if (show) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (show) begin
			word_q <= masked;
			count_q <= fit;
			lastw_q <= req.fin;
			eout_q <= err_new;
		end
	end

	assign out_valid = ov_q;
	assign out_word = word_q;
	assign out_count = count_q;
	assign last_word = lastw_q;
	assign error = eout_q;

endmodule
`default_nettype wire

// ----- rtl/lzd_checker.sv -----
// Port-level checker for the compressor, bound to the top level.
`default_nettype none
module lzd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        last_byte,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] out_word,
	input wire logic [3:0]  out_count,
	input wire logic        last_word,
	input wire logic [1:0]  error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(out_count))
		else $error("stalled output word changed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_count <= 4'd8 && (last_word || out_count != 4'd0))
		else $error("bad output byte count");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error != 2'd3)
		else $error("bad error code");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> in_stall)
		else $error("input taken again before final byte processed");

endmodule

bind lz77_fixed_huffman_deflate_top lzd_checker u_lzd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last_byte (last_byte),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word),
	.out_count (out_count),
	.last_word (last_word),
	.error     (error)
);
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for the deflate compressor: randomized byte streams checked word by word.
`default_nettype none

class deflate_board;
	logic [63:0] exp_word[$];
	logic [3:0]  exp_count[$];
	logic        exp_last[$];
	logic [1:0]  exp_err[$];
	int          fails;

	logic [31:0] cap;
	logic [7:0]  hist[int];
	logic [32:0] heads[int];
	logic [31:0] rcvd, epos, wrote;
	logic [63:0] pbits;
	int          pcnt;
	bit          hdr;
	logic [1:0]  err_l;

	function new();
		cap = 32'hFFFFFFFF;
		fails = 0;
		clear_stream();
	endfunction

	function void clear_stream();
		hist.delete();
		heads.delete();
		rcvd = 0;
		epos = 0;
		wrote = 0;
		pbits = 0;
		pcnt = 0;
		hdr = 0;
		err_l = lzd_pkg::ERR_NONE;
	endfunction

	function void latch(logic [1:0] c);
		if (err_l == lzd_pkg::ERR_NONE) err_l = c;
	endfunction

	function void push_word(int nb, bit fin);
		logic [31:0] room, fit;
		logic [63:0] w;
		room = (cap > wrote) ? cap - wrote : 0;
		fit = (nb < room) ? nb : room;
		if (fit < nb) latch(lzd_pkg::ERR_CAP);
		if (fit == 0 && !fin) begin
			pbits = 0;
			pcnt = 0;
			return;
		end
		w = (fit >= 8) ? pbits : (pbits & ((64'd1 << (8 * fit)) - 1));
		wrote += fit;
		exp_word.push_back(w);
		exp_count.push_back(fit[3:0]);
		exp_last.push_back(fin);
		exp_err.push_back(err_l);
		pbits = 0;
		pcnt = 0;
	endfunction

	function void bit_out(bit b);
		if (pcnt >= 64) push_word(8, 0);
		pbits[pcnt] = b;
		pcnt++;
	endfunction

	function void lsb_out(int v, int n);
		for (int i = 0; i < n; i++) bit_out(v[i]);
	endfunction

	function void msb_out(int v, int n);
		for (int i = n - 1; i >= 0; i--) bit_out(v[i]);
	endfunction

	function void sym_out(int s);
		if (s <= 143) msb_out(32'h30 + s, 8);
		else if (s <= 255) msb_out(32'h190 + s - 144, 9);
		else if (s <= 279) msb_out(s - 256, 7);
		else msb_out(32'hC0 + s - 280, 8);
	endfunction

	function logic [7:0] hb(logic [31:0] p);
		int k;
		k = int'(p[15:0]);
		return hist.exists(k) ? hist[k] : 8'd0;
	endfunction

	function void token();
		logic [31:0] i, avail, best, dist_v, v, h, ep, maxlen, m;
		logic [32:0] e;
		int li, di;
		i = epos;
		avail = rcvd - i;
		best = 0;
		dist_v = 0;
		if (avail >= 3) begin
			v = {8'd0, hb(i), hb(i + 1), hb(i + 2)};
			h = (v * 32'd2654435761) >> 19;
			e = heads.exists(h) ? heads[h] : 33'd0;
			ep = e[31:0];
			if (e[32] && ep < i && i - ep <= 32768) begin
				maxlen = avail < 258 ? avail : 258;
				m = 0;
				while (m < maxlen && hb(ep + m) == hb(i + m)) m++;
				if (m >= 3) begin
					best = m;
					dist_v = i - ep;
				end
			end
			heads[h] = {1'b1, i};
		end
		if (best >= 3) begin
			li = 0;
			for (int k = 0; k < 29; k++) if (lzd_pkg::LEN_BASE[k] <= best) li = k;
			sym_out(257 + li);
			lsb_out(best - lzd_pkg::LEN_BASE[li], lzd_pkg::LEN_EXTRA[li]);
			di = 0;
			for (int k = 0; k < 30; k++) if (lzd_pkg::DIST_BASE[k] <= dist_v) di = k;
			msb_out(di, 5);
			lsb_out(dist_v - lzd_pkg::DIST_BASE[di], lzd_pkg::DIST_EXTRA[di]);
			epos = i + best;
		end else begin
			sym_out(hb(i));
			epos = i + 1;
		end
	endfunction

	function void note_byte(logic [7:0] d, bit fin);
		if (!hdr) begin
			lsb_out(1, 1);
			lsb_out(1, 2);
			hdr = 1;
		end
		if (rcvd == 32'hFFFFFFFF) latch(lzd_pkg::ERR_LONG);
		else begin
			hist[int'(rcvd[15:0])] = d;
			rcvd++;
		end
		while (rcvd - epos >= 258 || (fin && epos < rcvd)) token();
		if (fin) begin
			sym_out(256);
			push_word((pcnt + 7) / 8, 1);
			clear_stream();
		end
	endfunction

	function void check_word(logic [63:0] w, logic [3:0] c, logic l, logic [1:0] e);
		if (exp_word.size() == 0) begin
			$display("%0t unexpected word: actual %h count %0d", $time, w, c);
			fails++;
			return;
		end
		if (w !== exp_word[0] || c !== exp_count[0] || l !== exp_last[0] || e !== exp_err[0]) begin
			$display("%0t mismatch: expected %h/%0d/%0d/%0d actual %h/%0d/%0d/%0d", $time,
				exp_word[0], exp_count[0], exp_last[0], exp_err[0], w, c, l, e);
			fails++;
		end
		void'(exp_word.pop_front());
		void'(exp_count.pop_front());
		void'(exp_last.pop_front());
		void'(exp_err.pop_front());
	endfunction
endclass

module tb;
	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, last_byte = 0, out_valid, out_stall = 0, last_word;
	logic [7:0] data_byte = 0;
	logic [63:0] out_word;
	logic [3:0] out_count;
	logic [1:0] error;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	deflate_board board;
	int stall_mode = 0;

	lz77_fixed_huffman_deflate_top i_dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && !out_stall) board.check_word(out_word, out_count, last_word, error);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 6);
		endcase
	end

	task automatic write_cap(logic [31:0] v);
		@(posedge clk);
		psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= v; penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		board.cap = v;
	endtask

	// hold the byte until accepted; valid stays high across back-to-back bytes
	task automatic send_byte(logic [7:0] d, bit fin, bit keep);
		in_valid <= 1; data_byte <= d; last_byte <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_byte(d, fin);
		if (!keep) in_valid <= 0;
	endtask

	task automatic drain();
		int n;
		n = 0;
		while (board.exp_word.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (600) @(posedge clk);
	endtask

	task automatic send_stream(int len, int kind);
		int burst;
		int gap;
		bit fin;
		bit pause;
		logic [7:0] d;
		burst = 0;
		gap = 0;
		for (int k = 0; k < len; k++) begin
			case (kind)
				0: d = 8'($urandom);
				1: d = 8'($urandom_range(0, 3));
				2: d = 8'(k % 5) + 8'h61;
				default: d = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h41;
			endcase
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap = $urandom_range(0, 5);
			end
			burst--;
			fin = (k == len - 1);
			pause = (burst == 0) && (gap != 0);
			send_byte(d, fin, !fin && !pause);
			if (pause && !fin) repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		#10000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		// directed: single-byte streams at both extremes and at the 143/144 code boundary, then short repeats for matches
		send_byte(8'h00, 1, 1);
		send_byte(8'hFF, 1, 1);
		send_byte(8'h8F, 1, 1);
		send_byte(8'h90, 1, 0);
		drain();
		send_stream(8, 2);
		send_stream(12, 3);
		drain();
		write_cap(0);
		send_stream(3, 0);
		drain();
		write_cap(5);
		stall_mode = 1;
		send_stream(20, 0);
		drain();
		write_cap(32'hFFFFFFFF);
		for (int s = 0; s < 6; s++) begin
			stall_mode = s % 3;
			send_stream($urandom_range(5, 20), s % 4);
			drain();
		end
		write_cap(12);
		send_stream(15, 0);
		drain();
		write_cap(32'hFFFFFFFF);
		stall_mode = 2;
		send_stream(90, 2);
		drain();
		if (board.fails == 0 && board.exp_word.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/lzd_pkg.sv
rtl/lzd_packer.sv
rtl/lz77_fixed_huffman_deflate_top.sv
rtl/lzd_checker.sv
test/tb.sv
